### rtl/lbcd_pkg.sv
// lbcd_pkg: shared types and constants of the block cache directory
`default_nettype none

package lbcd_pkg;

  localparam int ASSET_W = 8;
  localparam int BLOCK_W = 16;
  localparam int SIZE_W  = 24;
  localparam int SLOT_W  = 2;
  localparam int FILL_W  = 13;
  localparam int STAMP_W = 32;
  // index width inside the chain, wide enough for the largest slot count
  localparam int IDX_W   = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } state_t;

  // token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic                 vld;
    logic [ASSET_W-1:0]   asset;
    logic [BLOCK_W-1:0]   block;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [STAMP_W-1:0]   min_stamp;
    logic [IDX_W-1:0]     min_idx;
  } probe_t;

  // slot write broadcast from the controller
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [ASSET_W-1:0]   asset;
    logic [BLOCK_W-1:0]   block;
    logic [STAMP_W-1:0]   stamp;
  } upd_t;

endpackage

`default_nettype wire

### rtl/lbcd_req_if.sv
// lbcd_req_if: request channel of the block cache directory
`default_nettype none

interface lbcd_req_if;
  logic                          valid;
  logic                          ready;
  logic [lbcd_pkg::ASSET_W-1:0]  asset_id;
  logic [lbcd_pkg::BLOCK_W-1:0]  block_number;
  logic [lbcd_pkg::SIZE_W-1:0]   asset_size;

  modport source (output valid, output asset_id, output block_number, output asset_size,
                  input ready);
  modport sink (input valid, input asset_id, input block_number, input asset_size,
                output ready);
endinterface

`default_nettype wire

### rtl/lbcd_rsp_if.sv
// lbcd_rsp_if: result channel of the block cache directory
`default_nettype none

interface lbcd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lbcd_pkg::SLOT_W-1:0]  slot;
  logic [lbcd_pkg::FILL_W-1:0]  fill_bytes;

  modport source (output valid, output hit, output slot, output fill_bytes, input ready);
  modport sink (input valid, input hit, input slot, input fill_bytes, output ready);
endinterface

`default_nettype wire

### rtl/lbcd_cell.sv
// lbcd_cell: one directory slot, tag compare and lru stamp compare stage
`default_nettype none

module lbcd_cell #(
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lbcd_pkg::probe_t probe_in,
  input  wire lbcd_pkg::upd_t   upd,
  output lbcd_pkg::probe_t      probe_out
);

  logic                            valid;
  logic [lbcd_pkg::ASSET_W-1:0]    asset;
  logic [lbcd_pkg::BLOCK_W-1:0]    block;
  logic [lbcd_pkg::STAMP_W-1:0]    stamp;
  logic                            match;
  logic                            older;
  lbcd_pkg::probe_t                probe_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      asset <= '0;
      block <= '0;
      stamp <= '0;
    end else if (upd.en && upd.idx == lbcd_pkg::IDX_W'(IDX)) begin
      valid <= 1'b1;
      asset <= upd.asset;
      block <= upd.block;
      stamp <= upd.stamp;
    end
  end

  assign match = valid && asset == probe_in.asset && block == probe_in.block;
  // strict compare keeps the lower index on equal stamps
  assign older = stamp < probe_in.min_stamp;

  always_comb begin
    probe_next           = probe_in;
    probe_next.hit       = probe_in.hit | match;
    probe_next.hit_idx   = probe_in.hit ? probe_in.hit_idx : lbcd_pkg::IDX_W'(IDX);
    probe_next.min_stamp = older ? stamp : probe_in.min_stamp;
    probe_next.min_idx   = older ? lbcd_pkg::IDX_W'(IDX) : probe_in.min_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule

`default_nettype wire

### rtl/lbcd_fill.sv
// lbcd_fill: fill length of a block, clamped to the block size
`default_nettype none

module lbcd_fill #(
  parameter int BLOCK_BYTES = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          start_en,
  input  wire logic                          fill_en,
  input  wire logic [lbcd_pkg::BLOCK_W-1:0]  block_number,
  input  wire logic [lbcd_pkg::SIZE_W-1:0]   asset_size,
  output logic [lbcd_pkg::FILL_W-1:0]        fill_bytes
);

  localparam int BB_W    = $clog2(BLOCK_BYTES + 1);
  localparam int START_W = lbcd_pkg::BLOCK_W + BB_W;

  logic [START_W-1:0] start;
  logic [START_W-1:0] size_ext;
  logic [START_W-1:0] diff;
  logic               over;
  logic               clamp;
  logic [BB_W-1:0]    fill_len;

  // block start offset, registered ahead of the compare
  always_ff @(posedge clk) begin
    if (start_en) begin
      start <= START_W'(block_number) * START_W'(BLOCK_BYTES);
    end
  end

  assign size_ext = START_W'(asset_size);
  assign over     = start > size_ext;
  assign diff     = size_ext - start;
  assign clamp    = over || diff > START_W'(BLOCK_BYTES);

  always_ff @(posedge clk) begin
    if (fill_en) begin
      fill_len <= clamp ? BB_W'(BLOCK_BYTES) : diff[BB_W-1:0];
    end
  end

  assign fill_bytes = lbcd_pkg::FILL_W'(fill_len);

endmodule

`default_nettype wire

### rtl/lru_block_cache_directory_unit.sv
// lru_block_cache_directory_unit: lru directory of a small fully associative block cache
// Usage: each request on req carries asset_id, block_number and asset_size; the
// block answers with one result on rsp: hit, the slot holding or receiving the
// block, and fill_bytes, the byte count a fill must decode (0 on a hit).
// Both channels use valid/ready; a request or result moves at an edge where
// both are high.
// Each slot is a cell in a chain. A probe token carrying the tag enters cell 0
// the cycle after the request is taken and moves one cell per cycle, picking up
// the hit and the oldest stamp (lowest index on ties) on the way.
// One request is in flight at a time: a new request is taken only after the
// previous one has walked the probe down the cell chain and made its slot write.
// The result sits in an output register; if the receiver stalls, the next
// request is still taken and walks the chain, then waits before its slot write
// until the pending result is taken.
// Reset (synchronous, active high) empties all slots, zeroes their stamps and
// the shared use counter; no request is taken while reset is high.
`default_nettype none

module lru_block_cache_directory_unit #(
  parameter int NUM_SLOTS   = 3,
  parameter int BLOCK_BYTES = 4096
) (
  input wire logic   clk,
  input wire logic   rst,
  lbcd_req_if.sink   req,
  lbcd_rsp_if.source rsp
);

  // request tag, held while the probe walks
  logic [lbcd_pkg::ASSET_W-1:0]  req_asset;
  logic [lbcd_pkg::BLOCK_W-1:0]  req_block;
  logic [lbcd_pkg::SIZE_W-1:0]   req_size;

  lbcd_pkg::state_t              state;
  lbcd_pkg::state_t              state_next;
  logic                          launch;
  logic [lbcd_pkg::STAMP_W-1:0]  use_clock;

  // probe token chain, entry k feeds cell k
  lbcd_pkg::probe_t              chain [NUM_SLOTS+1];
  lbcd_pkg::probe_t              found;
  lbcd_pkg::upd_t                upd;

  logic                          accept;
  logic                          probe_done;
  logic                          commit;
  logic [lbcd_pkg::FILL_W-1:0]   fill_len;

  logic                          rsp_valid;
  logic                          rsp_hit;
  logic [lbcd_pkg::SLOT_W-1:0]   rsp_slot;
  logic [lbcd_pkg::FILL_W-1:0]   rsp_fill;

  assign probe_done = chain[NUM_SLOTS].vld;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lbcd_pkg::ST_IDLE:   if (req.valid) state_next = lbcd_pkg::ST_SEARCH;
      lbcd_pkg::ST_SEARCH: if (probe_done) state_next = lbcd_pkg::ST_COMMIT;
      lbcd_pkg::ST_COMMIT: if (!rsp_valid || rsp.ready) state_next = lbcd_pkg::ST_IDLE;
      default:             state_next = lbcd_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready = 1'b0;
    commit    = 1'b0;
    unique case (state)
      lbcd_pkg::ST_IDLE:   req.ready = !rst;
      lbcd_pkg::ST_SEARCH: ;
      lbcd_pkg::ST_COMMIT: commit = !rsp_valid || rsp.ready;
      default:             ;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lbcd_pkg::ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_asset <= req.asset_id;
      req_block <= req.block_number;
      req_size  <= req.asset_size;
    end
  end

  // head of the chain: no hit yet, oldest stamp seeded at the maximum
  always_comb begin
    chain[0]           = '0;
    chain[0].vld       = launch;
    chain[0].asset     = req_asset;
    chain[0].block     = req_block;
    chain[0].min_stamp = '1;
  end

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    lbcd_cell #(
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (chain[k]),
      .upd       (upd),
      .probe_out (chain[k+1])
    );
  end

  // latch the finished probe until the slot write
  always_ff @(posedge clk) begin
    if (probe_done) begin
      found <= chain[NUM_SLOTS];
    end
  end

  lbcd_fill #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_fill (
    .clk          (clk),
    .start_en     (launch),
    .fill_en      (probe_done),
    .block_number (req_block),
    .asset_size   (req_size),
    .fill_bytes   (fill_len)
  );

  // slot write: the hit slot is restamped, otherwise the victim is retagged
  always_comb begin
    upd.en    = commit;
    upd.idx   = found.hit ? found.hit_idx : found.min_idx;
    upd.asset = req_asset;
    upd.block = req_block;
    upd.stamp = use_clock + lbcd_pkg::STAMP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_clock <= '0;
    end else if (commit) begin
      use_clock <= upd.stamp;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp_hit  <= found.hit;
      rsp_slot <= upd.idx[lbcd_pkg::SLOT_W-1:0];
      rsp_fill <= found.hit ? '0 : fill_len;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.slot       = rsp_slot;
  assign rsp.fill_bytes = rsp_fill;

endmodule

`default_nettype wire

### tb/tb_lru_block_cache_directory_unit.sv
// testbench of the lru block cache directory: lookup prediction, result checks, idle and stall phases
`default_nettype none

typedef struct packed {
  logic                         hit;
  logic [lbcd_pkg::SLOT_W-1:0]  slot;
  logic [lbcd_pkg::FILL_W-1:0]  fill_bytes;
} lookup_result_t;

class slot_lookup_scoreboard #(parameter int SLOTS = 3, parameter int BLK_BYTES = 4096);
  bit                          tag_valid [SLOTS];
  logic [lbcd_pkg::ASSET_W-1:0] tag_asset [SLOTS];
  logic [lbcd_pkg::BLOCK_W-1:0] tag_block [SLOTS];
  logic [lbcd_pkg::STAMP_W-1:0] tag_stamp [SLOTS];
  logic [lbcd_pkg::STAMP_W-1:0] use_count;
  lookup_result_t              lookup_results_due [$];
  int                          errors;
  int                          n_hit;
  int                          n_fill;
  int                          n_full_fill;
  int                          n_empty_fill;

  function new();
    for (int i = 0; i < SLOTS; i++) begin
      tag_valid[i] = 1'b0;
      tag_asset[i] = '0;
      tag_block[i] = '0;
      tag_stamp[i] = '0;
    end
    use_count = '0;
    errors = 0;
    n_hit = 0;
    n_fill = 0;
    n_full_fill = 0;
    n_empty_fill = 0;
  endfunction

  // work out the directory's answer to one taken request and update the tags
  function void note_request(logic [lbcd_pkg::ASSET_W-1:0] asset,
                             logic [lbcd_pkg::BLOCK_W-1:0] block,
                             logic [lbcd_pkg::SIZE_W-1:0] size);
    lookup_result_t    r;
    int                victim;
    bit                found;
    longint unsigned   first_byte;
    longint unsigned   span;
    victim = 0;
    found = 1'b0;
    r = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found) begin
        if (tag_valid[i] && tag_asset[i] == asset && tag_block[i] == block) begin
          use_count = use_count + 1;
          tag_stamp[i] = use_count;
          r.hit = 1'b1;
          r.slot = i[lbcd_pkg::SLOT_W-1:0];
          r.fill_bytes = '0;
          found = 1'b1;
        end else if (tag_stamp[i] < tag_stamp[victim]) begin
          victim = i;
        end
      end
    end
    if (found) begin
      n_hit++;
    end else begin
      first_byte = longint'(block) * BLK_BYTES;
      // a block starting past the end decodes a whole block
      if (first_byte > longint'(size)) begin
        span = BLK_BYTES;
      end else begin
        span = longint'(size) - first_byte;
        if (span > BLK_BYTES) span = BLK_BYTES;
      end
      if (span == BLK_BYTES) n_full_fill++;
      if (span == 0) n_empty_fill++;
      n_fill++;
      tag_valid[victim] = 1'b1;
      tag_asset[victim] = asset;
      tag_block[victim] = block;
      use_count = use_count + 1;
      tag_stamp[victim] = use_count;
      r.hit = 1'b0;
      r.slot = victim[lbcd_pkg::SLOT_W-1:0];
      r.fill_bytes = span[lbcd_pkg::FILL_W-1:0];
    end
    lookup_results_due.push_back(r);
  endfunction

  function void check_result(logic hit, logic [lbcd_pkg::SLOT_W-1:0] slot,
                             logic [lbcd_pkg::FILL_W-1:0] fill_bytes);
    lookup_result_t want;
    if (lookup_results_due.size() == 0) begin
      $error("result with no request outstanding: hit %0d slot %0d fill_bytes %0d",
             hit, slot, fill_bytes);
      errors++;
    end else begin
      want = lookup_results_due.pop_front();
      if (hit !== want.hit) begin
        $error("hit mismatch: expected %0d, got %0d", want.hit, hit);
        errors++;
      end
      if (slot !== want.slot) begin
        $error("slot mismatch: expected %0d, got %0d", want.slot, slot);
        errors++;
      end
      if (fill_bytes !== want.fill_bytes) begin
        $error("fill_bytes mismatch: expected %0d, got %0d", want.fill_bytes, fill_bytes);
        errors++;
      end
    end
  endfunction

  function int pending();
    return lookup_results_due.size();
  endfunction
endclass

module tb_lru_block_cache_directory_unit;

  localparam int NUM_SLOTS    = 3;
  localparam int BLOCK_BYTES  = 4096;
  localparam int RANDOM_ITEMS = 528;
  // the slowest legal run stays far below this
  localparam int CYCLE_LIMIT  = 400000;
  // request-to-result latency plus margin
  localparam int SETTLE_CYCLES = NUM_SLOTS + 20;

  logic clk;
  logic rst;

  lbcd_req_if req_ch ();
  lbcd_rsp_if rsp_ch ();

  lru_block_cache_directory_unit #(
    .NUM_SLOTS   (NUM_SLOTS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slot_lookup_scoreboard #(NUM_SLOTS, BLOCK_BYTES) dir_sb;

  // idle rates in percent, set by the stimulus per phase
  int tx_idle_pct;
  int rx_idle_pct;
  // long receiver hold asked by the stimulus, counted down by the receiver
  int rx_hold_req;
  int cycle_count = 0;
  int n_sent = 0;
  int n_results = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_lru_block_cache_directory_unit NOT OK");
      $finish;
    end
  end

  // offer one request, with random idle cycles first, and wait for it to be taken
  task automatic offer_request(input logic [lbcd_pkg::ASSET_W-1:0] asset,
                               input logic [lbcd_pkg::BLOCK_W-1:0] block,
                               input logic [lbcd_pkg::SIZE_W-1:0] size);
    while ($urandom_range(99) < tx_idle_pct) begin
      // idle: valid low, payload is noise the block must ignore
      req_ch.valid        <= 1'b0;
      req_ch.asset_id     <= lbcd_pkg::ASSET_W'($urandom);
      req_ch.block_number <= lbcd_pkg::BLOCK_W'($urandom);
      req_ch.asset_size   <= lbcd_pkg::SIZE_W'($urandom);
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.asset_id     <= asset;
    req_ch.block_number <= block;
    req_ch.asset_size   <= size;
    do @(posedge clk); while (!req_ch.ready);
    dir_sb.note_request(asset, block, size);
    n_sent++;
  endtask

  // sender pause until every outstanding lookup has answered
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (dir_sb.pending() != 0) @(posedge clk);
  endtask

  // receiver: samples results at the edge, then picks ready for the next cycle
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        dir_sb.check_result(rsp_ch.hit, rsp_ch.slot, rsp_ch.fill_bytes);
        n_results++;
      end
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        // long stall: the block fills up and must back-pressure its input
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [lbcd_pkg::ASSET_W-1:0] asset;
    logic [lbcd_pkg::BLOCK_W-1:0] block;
    logic [lbcd_pkg::SIZE_W-1:0]  size;
    logic [31:0]                  base;
    int                           pick;
    dir_sb = new();
    rx_hold_req = 0;
    tx_idle_pct = 30;
    rx_idle_pct = 75;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.asset_id     <= '0;
    req_ch.block_number <= '0;
    req_ch.asset_size   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty asset, block starting exactly at the end, then a hit on it
    offer_request(8'h00, 16'h0000, 24'h000000);
    offer_request(8'h00, 16'h0000, 24'h000000);
    // all-ones fields: last block far past the end fills a whole block
    offer_request(8'hff, 16'hffff, 24'hffffff);
    // last partial block of the largest asset
    offer_request(8'hff, 16'h0fff, 24'hffffff);
    // first block past the end of the largest asset
    offer_request(8'h01, 16'h1000, 24'hffffff);
    // exact end, full block, short last block
    offer_request(8'h02, 16'h0003, 24'd12288);
    offer_request(8'h02, 16'h0002, 24'd12288);
    offer_request(8'h02, 16'h0001, 24'd5000);
    offer_request(8'h02, 16'h0002, 24'd12288);
    // same block of another asset, same asset with another block: both miss
    offer_request(8'h03, 16'h0002, 24'd12288);
    offer_request(8'h02, 16'h0004, 24'd12288);
    // alternating bit patterns
    offer_request(8'haa, 16'h5555, 24'haaaaaa);
    offer_request(8'h55, 16'haaaa, 24'h555555);
    // lru order: fill a, b, c, touch a, then d must evict b
    offer_request(8'h10, 16'h0000, 24'd100);
    offer_request(8'h11, 16'h0000, 24'd100);
    offer_request(8'h12, 16'h0000, 24'd100);
    offer_request(8'h10, 16'h0000, 24'd100);
    offer_request(8'h13, 16'h0000, 24'd100);
    offer_request(8'h11, 16'h0000, 24'd100);
    offer_request(8'h10, 16'h0000, 24'd100);
    // size one byte past a block boundary, and one byte short of it
    offer_request(8'h20, 16'h0001, 24'd4097);
    offer_request(8'h20, 16'h0002, 24'd8191);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 180) begin
        tx_idle_pct = 75;
        rx_idle_pct = 30;
      end
      if (n == 360) begin
        // sender pause, then a long receiver hold with the sender flat out
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 150;
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        // tiny working set: frequent hits and evictions among few tags
        asset = lbcd_pkg::ASSET_W'($urandom_range(0, 1));
        block = lbcd_pkg::BLOCK_W'($urandom_range(0, 2));
      end else if (pick < 80) begin
        asset = lbcd_pkg::ASSET_W'($urandom_range(0, 7));
        block = lbcd_pkg::BLOCK_W'($urandom_range(0, 15));
      end else begin
        asset = lbcd_pkg::ASSET_W'($urandom);
        block = lbcd_pkg::BLOCK_W'($urandom);
      end
      base = 32'(block) * BLOCK_BYTES;
      pick = $urandom_range(99);
      if (pick < 50) begin
        size = lbcd_pkg::SIZE_W'(base + $urandom_range(0, 2 * BLOCK_BYTES - 1));
      end else if (pick < 60) begin
        size = lbcd_pkg::SIZE_W'(base);
      end else if (pick < 70) begin
        size = lbcd_pkg::SIZE_W'(base - $urandom_range(1, BLOCK_BYTES));
      end else begin
        size = lbcd_pkg::SIZE_W'($urandom);
      end
      offer_request(asset, block, size);
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (dir_sb.pending() != 0) @(posedge clk);
    // let any stray result show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (dir_sb.pending() != 0) begin
      $error("%0d lookups never answered", dir_sb.pending());
      dir_sb.errors++;
    end

    $display("run covered %0d requests and %0d results: %0d hits, %0d fills",
             n_sent, n_results, dir_sb.n_hit, dir_sb.n_fill);
    $display("fills of a whole block: %0d, zero-length fills: %0d, cycles: %0d",
             dir_sb.n_full_fill, dir_sb.n_empty_fill, cycle_count);
    if (dir_sb.errors == 0) begin
      $display("tb_lru_block_cache_directory_unit OK");
    end else begin
      $display("tb_lru_block_cache_directory_unit NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/lbcd_pkg.sv
rtl/lbcd_req_if.sv
rtl/lbcd_rsp_if.sv
rtl/lbcd_cell.sv
rtl/lbcd_fill.sv
rtl/lru_block_cache_directory_unit.sv
tb/tb_lru_block_cache_directory_unit.sv
